@@ rtl/rme_pkg.sv @@
// ============================================================================
// rme_pkg
// Shared constants, types and the arctangent table for the Euler angle core.
// ============================================================================
package rme_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ANGLE_TABLE_LEN = 24;
    localparam int NUM_STAGES = (CORDIC_STAGES < ANGLE_TABLE_LEN) ? CORDIC_STAGES
                                                                    : ANGLE_TABLE_LEN;
    localparam int ONE_Q14 = 16384;
    // Operand width inside the CORDIC: 16 bit input scaled by 256, plus growth.
    localparam int VW = 28;
    // Square root stages: 15 result bits for a radicand below 2^29.
    localparam int SQRT_STAGES = 15;
    localparam int QDEPTH = 4;
    localparam int QAW = 2;

    localparam logic [31:0] ATAN_TURNS [ANGLE_TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
        32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
        32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81
    };

    // Classified item passed from the front to the back part.
    typedef struct packed {
        logic               lock;
        logic               m20_neg;
        logic signed [15:0] ry;
        logic signed [15:0] rx;
        logic signed [15:0] yy;
        logic signed [15:0] yx;
        logic signed [15:0] s;
        logic [28:0]        rad;
    } rme_item_t;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic               lock;
    } rme_result_t;

endpackage

@@ rtl/rme_front.sv @@
// ============================================================================
// rme_front
// Accepts a matrix, chooses the branch and forms the asin operands.
// ============================================================================
module rme_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [111:0]        in_data,
    input  logic [7:0]          tol,
    output logic                q_valid,
    input  logic                q_ready,
    output rme_pkg::rme_item_t  q_item
);

    logic signed [15:0] m00, m01, m02, m10, m20, m21, m22;
    logic signed [16:0] mag, gap;
    logic signed [15:0] s;
    logic signed [31:0] ss;
    logic               valid_reg;
    rme_pkg::rme_item_t item_reg, item_next;

    assign {m22, m21, m20, m10, m02, m01, m00} = in_data;

    // Branch selection and operand routing.
    always_comb
    begin
        mag = m20[15] ? -{m20[15], m20} : {m20[15], m20};
        gap = mag - 17'sd16384;
        if (gap[16])
            gap = -gap;
        if (m20 > 16'sd16384)
            s = 16'sd16384;
        else if (m20 < -16'sd16384)
            s = -16'sd16384;
        else
            s = m20;
        ss = s * s;
        item_next.lock    = (gap <= $signed({9'd0, tol}));
        item_next.m20_neg = m20[15];
        item_next.ry      = item_next.lock ? m01 : m21;
        item_next.rx      = item_next.lock ? m02 : m22;
        item_next.yy      = m10;
        item_next.yx      = m00;
        item_next.s       = s;
        item_next.rad     = 29'(32'd268435456 - 32'(ss));
    end

    assign in_ready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;
    assign q_item   = item_reg;

    // Output register of the front part.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= item_next;
    end

endmodule

@@ rtl/rme_queue.sv @@
// ============================================================================
// rme_queue
// Short queue between the front and back parts.
// ============================================================================
module rme_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  rme_pkg::rme_item_t  wr_item,
    output logic                rd_valid,
    input  logic                rd_ready,
    output rme_pkg::rme_item_t  rd_item
);

    rme_pkg::rme_item_t     mem [rme_pkg::QDEPTH];
    logic [rme_pkg::QAW-1:0] wp_reg, rp_reg;
    logic [rme_pkg::QAW:0]   cnt_reg;
    logic                    wr, rd;

    assign wr_ready = (cnt_reg != 3'(rme_pkg::QDEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_item  = mem[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {2'd0, wr} - {2'd0, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wr_item;
    end

endmodule

@@ rtl/rme_back.sv @@
// ============================================================================
// rme_back
// Square root and three CORDIC pipelines, one stage each cycle while the skid is empty.
// ============================================================================
module rme_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  rme_pkg::rme_item_t   q_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rme_pkg::rme_result_t out_res
);

    localparam int SQ = rme_pkg::SQRT_STAGES;
    localparam int NS = rme_pkg::NUM_STAGES;
    localparam int VW = rme_pkg::VW;
    localparam int DEPTH = SQ + 1 + NS + 1;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic [31:0]          z;
        logic                 zero;
    } cvec_t;

    // The whole pipeline advances while the skid register is empty.
    logic              adv;
    logic [DEPTH-1:0]  v_reg;
    logic              sk_valid_reg;
    rme_pkg::rme_result_t sk_reg, last_res;

    // Square root stage arrays.
    rme_pkg::rme_item_t it_reg [SQ+1];
    logic [28:0]        rem_reg [SQ+1];
    logic [28:0]        res_reg [SQ+1];

    // CORDIC arrays for roll, yaw and asin, stage 0 holds the prepared vector.
    cvec_t cr_reg [NS+1];
    cvec_t cy_reg [NS+1];
    cvec_t cp_reg [NS+1];
    logic  lk_reg [NS+1];
    logic  ng_reg [NS+1];

    assign adv     = !sk_valid_reg;
    assign q_ready = adv;

    function automatic cvec_t prep(input logic signed [15:0] y, input logic signed [15:0] x);
        cvec_t v;
        v.zero = (x == 0) && (y == 0);
        v.x = VW'(x) <<< 8;
        v.y = VW'(y) <<< 8;
        v.z = '0;
        if (x[15])
        begin
            v.x = -v.x;
            v.y = -v.y;
            v.z = 32'h8000_0000;
        end
        return v;
    endfunction

    function automatic cvec_t rot(input cvec_t v, input int i);
        cvec_t o;
        o = v;
        if (!v.y[VW-1])
        begin
            o.x = v.x + (v.y >>> i);
            o.y = v.y - (v.x >>> i);
            o.z = v.z + rme_pkg::ATAN_TURNS[i];
        end
        else
        begin
            o.x = v.x - (v.y >>> i);
            o.y = v.y + (v.x >>> i);
            o.z = v.z - rme_pkg::ATAN_TURNS[i];
        end
        return o;
    endfunction

    function automatic logic [15:0] fin(input cvec_t v);
        logic [31:0] t;
        t = v.z + 32'h8000;
        return v.zero ? 16'd0 : t[31:16];
    endfunction

    // Valid pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[DEPTH-2:0], q_valid};
    end

    // Square root, one result bit a stage.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it_reg[0]  <= q_item;
            rem_reg[0] <= q_item.rad;
            res_reg[0] <= '0;
            for (int k = 0; k < SQ; k++)
            begin
                logic [28:0] b;
                logic [28:0] t;
                b = 29'd1 << (2 * (SQ - 1 - k));
                t = res_reg[k] + b;
                it_reg[k+1] <= it_reg[k];
                if (rem_reg[k] >= t)
                begin
                    rem_reg[k+1] <= rem_reg[k] - t;
                    res_reg[k+1] <= (res_reg[k] >> 1) + b;
                end
                else
                begin
                    rem_reg[k+1] <= rem_reg[k];
                    res_reg[k+1] <= res_reg[k] >> 1;
                end
            end
        end
    end

    // CORDIC stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cr_reg[0] <= prep(it_reg[SQ].ry, it_reg[SQ].rx);
            cy_reg[0] <= prep(it_reg[SQ].yy, it_reg[SQ].yx);
            cp_reg[0] <= prep(it_reg[SQ].s, 16'(res_reg[SQ]));
            lk_reg[0] <= it_reg[SQ].lock;
            ng_reg[0] <= it_reg[SQ].m20_neg;
            for (int i = 0; i < NS; i++)
            begin
                cr_reg[i+1] <= rot(cr_reg[i], i);
                cy_reg[i+1] <= rot(cy_reg[i], i);
                cp_reg[i+1] <= rot(cp_reg[i], i);
                lk_reg[i+1] <= lk_reg[i];
                ng_reg[i+1] <= ng_reg[i];
            end
        end
    end

    // Final rounding and branch merge.
    always_comb
    begin
        logic [15:0]        pa;
        logic signed [16:0] p;
        pa = fin(cp_reg[NS]);
        p = -$signed({pa[15], pa});
        if (p > 17'sd16384)
            p = 17'sd16384;
        if (p < -17'sd16384)
            p = -17'sd16384;
        last_res.roll = fin(cr_reg[NS]);
        last_res.lock = lk_reg[NS];
        if (lk_reg[NS])
        begin
            last_res.yaw   = '0;
            last_res.pitch = ng_reg[NS] ? 16'sd16384 : -16'sd16384;
        end
        else
        begin
            last_res.yaw   = fin(cy_reg[NS]);
            last_res.pitch = p[15:0];
        end
    end

    // Skid register catches the result emerging during a stall.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sk_valid_reg <= 1'b0;
        else if (sk_valid_reg)
            sk_valid_reg <= !out_ready;
        else
            sk_valid_reg <= v_reg[DEPTH-1] && !out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (!sk_valid_reg)
            sk_reg <= last_res;
    end

    assign out_valid = sk_valid_reg || v_reg[DEPTH-1];
    assign out_res   = sk_valid_reg ? sk_reg : last_res;

endmodule

@@ rtl/rotation_matrix_to_euler_core.sv @@
// ============================================================================
// rotation_matrix_to_euler_core
// Z-Y-X Euler angles from a rotation matrix using pipelined CORDIC atan2.
// ============================================================================
// Channel  Dir  Contents
// s_axis   in   seven matrix elements, Q2.14
// m_axis   out  roll, pitch, yaw angles and gimbal flag
// cfg      in   gimbal tolerance, 8 bit
//
// One item enters every cycle unless the output stalls; an item passes through
// the front register, the queue, 15 square root stages, one preparation stage
// and CORDIC_STAGES rotation stages in series.
// Reset clears all valid flags and sets the tolerance to 1.
// A stalled output is held in a skid register; while it is full the back part
// waits, the queue fills and the input is then held off.
// ============================================================================
module rotation_matrix_to_euler_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // m00, m01, m02, m10, m20, m21, m22 from the lowest bit up
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // roll_angle, pitch_angle, yaw_angle from the lowest bit up
    output logic [47:0]  m_axis_tdata,
    // gimbal_lock
    output logic         m_axis_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data
);

    logic [7:0]           tol_reg;
    logic                 fq_valid, fq_ready, qb_valid, qb_ready;
    rme_pkg::rme_item_t   fq_item, qb_item;
    rme_pkg::rme_result_t res;

    // Tolerance register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= 8'd1;
        else if (cfg_valid)
            tol_reg <= cfg_data;
    end

    rme_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
        .tol(tol_reg),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_item(fq_item)
    );

    rme_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_item(fq_item),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_item(qb_item)
    );

    rme_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(qb_valid), .q_ready(qb_ready), .q_item(qb_item),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
    );

    assign m_axis_tdata = {res.yaw, res.pitch, res.roll};
    assign m_axis_tuser = res.lock;

endmodule

@@ dv/tb_top.sv @@
// ============================================================================
// Euler angle core testbench
// Drives matrices through the stream input with random idling on both sides,
// predicts roll, pitch, yaw and the gimbal flag for each accepted item, and
// compares every output item with the oldest prediction.
// ============================================================================
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [15:0] yaw;
        logic        lock;
    } angles_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_data;

    angles_t     angles_due[$];
    logic [7:0]  tolerance;
    int          errors;
    int          items_sent;
    int          items_checked;
    bit          calm;
    int          out_stall;

    rotation_matrix_to_euler_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Floor division by a power of two for signed values.
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r;
        r = 0;
        while ((r + 1) * (r + 1) <= v)
            r = r + 1;
        return r;
    endfunction

    // Vectoring CORDIC arctangent as a 16 bit binary angle.
    function automatic logic [15:0] cordic_angle(int y, int x);
        longint      vx;
        longint      vy;
        longint      dx;
        longint      dy;
        logic [31:0] z;
        vx = longint'(x) * 256;
        vy = longint'(y) * 256;
        z = 32'd0;
        if (x == 0 && y == 0)
            return 16'd0;
        if (vx < 0)
        begin
            vx = -vx;
            vy = -vy;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < rme_pkg::NUM_STAGES; i++)
        begin
            dx = floor_shift(vy, i);
            dy = floor_shift(vx, i);
            if (vy >= 0)
            begin
                vx += dx;
                vy -= dy;
                z += rme_pkg::ATAN_TURNS[i];
            end
            else
            begin
                vx -= dx;
                vy += dy;
                z -= rme_pkg::ATAN_TURNS[i];
            end
        end
        z = z + 32'h8000;
        return z[31:16];
    endfunction

    function automatic angles_t predict_angles(logic [111:0] d);
        angles_t r;
        int      m[7];
        int      gap;
        int      s;
        int      a;
        int      c;
        for (int k = 0; k < 7; k++)
            m[k] = int'($signed(d[16*k +: 16]));
        gap = (m[4] < 0 ? -m[4] : m[4]) - rme_pkg::ONE_Q14;
        if (gap < 0)
            gap = -gap;
        if (gap <= int'(tolerance))
        begin
            r.roll = cordic_angle(m[1], m[2]);
            r.yaw = 16'd0;
            r.pitch = (m[4] < 0) ? 16'd16384 : 16'hC000;
            r.lock = 1'b1;
        end
        else
        begin
            s = m[4];
            if (s > rme_pkg::ONE_Q14) s = rme_pkg::ONE_Q14;
            if (s < -rme_pkg::ONE_Q14) s = -rme_pkg::ONE_Q14;
            c = int'(int_sqrt(longint'(rme_pkg::ONE_Q14) * rme_pkg::ONE_Q14 - s * s));
            a = -int'($signed(cordic_angle(s, c)));
            if (a > rme_pkg::ONE_Q14) a = rme_pkg::ONE_Q14;
            if (a < -rme_pkg::ONE_Q14) a = -rme_pkg::ONE_Q14;
            r.pitch = a[15:0];
            r.roll = cordic_angle(m[5], m[6]);
            r.yaw = cordic_angle(m[3], m[0]);
            r.lock = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch on %s: got %0h, want %0h", what, got, want);
        errors++;
    endtask

    // The input goes idle for a random burst now and then.
    task automatic idle_cycles();
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    // Sends one matrix item and records its prediction on acceptance.
    task automatic send_matrix(logic [111:0] d);
        idle_cycles();
        s_axis_tdata <= d;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        angles_due.push_back(predict_angles(d));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (angles_due.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_tolerance(logic [7:0] v);
        drain();
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        tolerance = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [111:0] pack7(int a0, int a1, int a2, int a3, int a4,
                                           int a5, int a6);
        return {a6[15:0], a5[15:0], a4[15:0], a3[15:0], a2[15:0], a1[15:0],
                a0[15:0]};
    endfunction

    function automatic logic [111:0] random_matrix();
        logic [111:0] d;
        int           e;
        for (int k = 0; k < 4; k++)
            d[32*k +: 32] = $urandom();
        // Push m20 near plus or minus one often, to hit both branches.
        if ($urandom_range(0, 2) == 0)
        begin
            e = ($urandom_range(0, 1) ? 16384 : -16384) + $urandom_range(0, 600) - 300;
            d[64 +: 16] = e[15:0];
        end
        return d;
    endfunction

    // Output side: random back pressure and comparison.
    initial
    begin
        m_axis_tready = 1'b0;
        out_stall = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (angles_due.size() == 0)
                begin
                    report_mismatch("unexpected item roll", m_axis_tdata[15:0], 16'd0);
                end
                else
                begin
                    angles_t w;
                    w = angles_due.pop_front();
                    if (m_axis_tdata[15:0] !== w.roll)
                        report_mismatch("roll", m_axis_tdata[15:0], w.roll);
                    if (m_axis_tdata[31:16] !== w.pitch)
                        report_mismatch("pitch", m_axis_tdata[31:16], w.pitch);
                    if (m_axis_tdata[47:32] !== w.yaw)
                        report_mismatch("yaw", m_axis_tdata[47:32], w.yaw);
                    if (m_axis_tuser !== w.lock)
                        report_mismatch("gimbal", {15'd0, m_axis_tuser}, {15'd0, w.lock});
                    items_checked++;
                end
            end
            @(negedge clk);
            if (out_stall > 0)
            begin
                out_stall--;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                out_stall = $urandom_range(0, 5);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic test_extremes();
        int v[6] = '{-32768, 32767, 0, 16384, -16384, 1};
        send_matrix(pack7(16384, 0, 0, 0, 0, 0, 16384));
        send_matrix(pack7(0, 0, 0, 0, 0, 0, 0));
        for (int k = 0; k < 6; k++)
            send_matrix(pack7(v[k], v[5-k], v[k], v[5-k], v[k], v[5-k], v[k]));
        send_matrix(pack7(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_matrix(pack7(32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_matrix(pack7(-100, 0, 0, 0, 0, 50, -200));
    endtask

    task automatic test_gimbal_edges();
        send_matrix(pack7(0, 300, -400, 5, 16384, 7, 8));
        send_matrix(pack7(0, -300, 400, 5, -16384, 7, 8));
        send_matrix(pack7(0, 3, 4, 5, 16385, 7, 8));
        send_matrix(pack7(0, 3, 4, 5, 16383, 7, 8));
        send_matrix(pack7(0, 3, 4, 5, -16386, 7, 8));
        send_matrix(pack7(0, 3, 4, 5, 16386, 7, 8));
        send_matrix(pack7(0, 0, 0, 0, 16384, 0, 0));
    endtask

    task automatic test_tolerance_settings();
        logic [7:0] t[4] = '{8'd0, 8'd255, 8'd37, 8'd1};
        for (int k = 0; k < 4; k++)
        begin
            write_tolerance(t[k]);
            send_matrix(pack7(1, 2, 3, 4, 16384 - int'(t[k]), 5, 6));
            send_matrix(pack7(1, 2, 3, 4, -16384 + int'(t[k]) + 1, 5, 6));
            send_matrix(pack7(1, 2, 3, 4, 16384 + int'(t[k]), 5, 6));
            repeat (150) send_matrix(random_matrix());
        end
    endtask

    task automatic test_random_calm();
        drain();
        calm = 1'b1;
        write_tolerance(8'($urandom_range(0, 255)));
        repeat (250) send_matrix(random_matrix());
    endtask

    // Timeout guard.
    initial
    begin
        #2ms;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        tolerance = 8'd1;
        errors = 0;
        items_sent = 0;
        items_checked = 0;
        calm = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_extremes();
        test_gimbal_edges();
        test_tolerance_settings();
        test_random_calm();
        drain();
        $display("covered %0d matrices, %0d results checked, tolerances 0, 1, 37, 255 and random",
                 items_sent, items_checked);
        if (errors == 0 && angles_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/rme_pkg.sv
rtl/rme_front.sv
rtl/rme_queue.sv
rtl/rme_back.sv
rtl/rotation_matrix_to_euler_core.sv
dv/tb_top.sv
